>>> sv/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and code tables for the URL percent
// decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] UTF8_LEAD  = 8'hC3;
    localparam logic [7:0] UTF8_BIAS  = 8'h40;
    localparam logic [7:0] LATIN_BASE = 8'hE0;

    localparam int unsigned MAX_OUT = 3;

    // One decoded input byte as handed from the front to the back.
    typedef struct packed {
        logic                     eos;
        logic [1:0]               cnt;
        logic [MAX_OUT-1:0][7:0]  bytes;
    } t_cmd;

    // Value of an upper-case hex digit; anything else gives zero.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9") begin
            d = c - 8'h30;
        end else if (c >= "A" && c <= "F") begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    // True if the byte is the first digit of at least one listed code.
    function automatic logic starts_code(input logic [7:0] c);
        return (c == "0") || (c == "2") || (c == "3") || (c == "4") ||
               (c == "5") || (c == "6") || (c == "7") || (c == "E");
    endfunction

    // True if the two digits form one of the listed codes.
    function automatic logic is_code(input logic [7:0] d1, input logic [7:0] d2);
        logic ok;
        logic up;
        up = (d2 >= "A") && (d2 <= "F");
        ok = 1'b0;
        unique case (d1)
            "0":     ok = (d2 == "D") || (d2 == "A");
            "2":     ok = ((d2 >= "0") && (d2 <= "9")) || up;
            "3":     ok = up;
            "4":     ok = (d2 == "0");
            "5":     ok = up && (d2 != "A");
            "6":     ok = (d2 == "0");
            "7":     ok = up && (d2 != "A") && (d2 != "F");
            "E":     ok = (d2 == "0") || (d2 == "7") || (d2 == "8") || (d2 == "9");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> sv/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, tracks the percent sequence state and turns each byte
// into a command of up to three output bytes.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_eos,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output upd_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    logic       r_cr,    n_cr;

    logic          fresh;
    logic [7:0]    val;
    upd_pkg::t_cmd cmd;

    assign o_ready = !i_q_full;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_cr      = r_cr;
        fresh     = 1'b0;
        cmd.eos   = i_eos;
        cmd.cnt   = 2'd0;
        cmd.bytes = '0;
        val       = {upd_pkg::hex_val(r_held), upd_pkg::hex_val(i_byte)};

        unique case (r_phase)
            PH_PCT: begin
                if (upd_pkg::starts_code(i_byte)) begin
                    n_held  = i_byte;
                    n_phase = PH_DIGIT;
                end else begin
                    cmd.bytes[cmd.cnt] = upd_pkg::CH_PERCENT;
                    cmd.cnt = cmd.cnt + 2'd1;
                    n_cr    = 1'b0;
                    n_phase = PH_IDLE;
                    fresh   = 1'b1;
                end
            end
            PH_DIGIT: begin
                n_phase = PH_IDLE;
                if (upd_pkg::is_code(r_held, i_byte)) begin
                    if (val == upd_pkg::CH_CR) begin
                        cmd.bytes[cmd.cnt] = upd_pkg::CH_LF;
                        cmd.cnt = cmd.cnt + 2'd1;
                        n_cr    = 1'b1;
                    end else if (val == upd_pkg::CH_LF) begin
                        // A line feed right after a decoded carriage return is dropped.
                        if (r_cr) begin
                            n_cr = 1'b0;
                        end else begin
                            cmd.bytes[cmd.cnt] = upd_pkg::CH_LF;
                            cmd.cnt = cmd.cnt + 2'd1;
                            n_cr    = 1'b0;
                        end
                    end else if (val >= upd_pkg::LATIN_BASE) begin
                        cmd.bytes[0] = upd_pkg::UTF8_LEAD;
                        cmd.bytes[1] = val - upd_pkg::UTF8_BIAS;
                        cmd.cnt = 2'd2;
                        n_cr    = 1'b0;
                    end else begin
                        cmd.bytes[cmd.cnt] = val;
                        cmd.cnt = cmd.cnt + 2'd1;
                        n_cr    = 1'b0;
                    end
                end else begin
                    cmd.bytes[0] = upd_pkg::CH_PERCENT;
                    cmd.bytes[1] = r_held;
                    cmd.cnt = 2'd2;
                    n_cr    = 1'b0;
                    fresh   = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                fresh   = 1'b1;
            end
        endcase

        if (fresh) begin
            if (i_byte == upd_pkg::CH_PERCENT) begin
                n_phase = PH_PCT;
            end else begin
                cmd.bytes[cmd.cnt] = (i_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE
                                                                  : i_byte;
                cmd.cnt = cmd.cnt + 2'd1;
                n_cr    = 1'b0;
            end
        end

        // At the end of the string any held characters go out literally.
        if (i_eos) begin
            if (n_phase == PH_PCT) begin
                cmd.bytes[cmd.cnt] = upd_pkg::CH_PERCENT;
                cmd.cnt = cmd.cnt + 2'd1;
            end else if (n_phase == PH_DIGIT) begin
                cmd.bytes[cmd.cnt] = upd_pkg::CH_PERCENT;
                cmd.cnt = cmd.cnt + 2'd1;
                cmd.bytes[cmd.cnt] = n_held;
                cmd.cnt = cmd.cnt + 2'd1;
            end
            n_phase = PH_IDLE;
            n_cr    = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_valid && o_ready && ((cmd.cnt != 2'd0) || i_eos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cr    <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_held <= n_held;
        end
    end

endmodule

>>> sv/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue
// Small register queue of decode commands between the front and the back.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output upd_pkg::t_cmd o_head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    upd_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// Walks through the bytes of the command at the queue head and sends them
// out one beat at a time, marking the last beat of each input byte.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  upd_pkg::t_cmd i_head,
    input  logic          i_ready,
    output logic          o_pop,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_byte_valid,
    output logic          o_run_last,
    output logic          o_string_end
);

    logic [1:0] r_idx;
    logic       fire;

    assign o_valid      = !i_empty;
    assign o_byte       = i_head.bytes[r_idx];
    assign o_byte_valid = (i_head.cnt != 2'd0);
    // An empty end marker is a run of its own.
    assign o_run_last   = (i_head.cnt == 2'd0) || (r_idx == i_head.cnt - 2'd1);
    assign o_string_end = o_run_last && i_head.eos;
    assign fire         = o_valid && i_ready;
    assign o_pop        = fire && o_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= o_run_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

>>> sv/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder: one encoded byte in, zero to three decoded
// bytes out.
// ----------------------------------------------------------------------------
// The decoder takes one encoded byte per clock unless its queue is full and
// sends one decoded beat per clock while the queue is not empty and the output
// is ready. Most input bytes give one beat, so the block sustains one byte per
// cycle when not stalled. A broken sequence or a UTF-8 letter can give two or
// three beats for one byte; the output port then sets the pace once the
// QUEUE_DEPTH-entry command queue between the decode front and the output
// sequencer has filled. A byte's command is registered in the queue before its
// first beat leaves. Each input byte's result carries tlast on its final beat;
// a string end that gives nothing yields one empty beat with byte_valid low.
module url_percent_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] in_byte
    input  logic       i_s_axis_tlast,  // end_of_string
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tlast,  // run_last
    output logic [1:0] o_m_axis_tuser   // [0] byte_valid, [1] string_end
);

    upd_pkg::t_cmd front_cmd, head_cmd;
    logic          push, pop, q_full, q_empty;
    logic          byte_valid, string_end;

    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .i_eos    (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    upd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (head_cmd),
        .i_ready      (i_m_axis_tready),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .o_byte       (o_m_axis_tdata),
        .o_byte_valid (byte_valid),
        .o_run_last   (o_m_axis_tlast),
        .o_string_end (string_end)
    );

    assign o_m_axis_tuser = {string_end, byte_valid};

endmodule
